>>> sv/base64_stream_encoder_top_assert.svh
// Assertion macros for the Base64 stream encoder.
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define B64E_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64e assertion failed");
// Next-cycle implication, checked outside reset.
`define B64E_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64e assertion failed");
`else
`define B64E_ASSERT_NOW(label, clk, rst, ante, cons)
`define B64E_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/b64e_pkg.sv
// Shared constants, types and the alphabet lookup for the Base64 stream encoder.
package b64e_pkg;

   localparam int unsigned MAX_CHARS = 6;
   localparam int unsigned CNT_W     = $clog2(MAX_CHARS + 1);

   localparam logic [4:0] GROUPS_PER_LINE = 5'd19;
   localparam logic [7:0] PAD_CHAR        = 8'h3D;
   localparam logic [7:0] NEWLINE_CHAR    = 8'h0A;

   // position of the next byte in its three-byte group
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   typedef logic [CNT_W-1:0] cnt_type;

   // standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [7:0] b64_char(input logic [5:0] idx);
      logic [7:0] r;
      if (idx < 6'd26) begin
         r = 8'h41 + {2'b00, idx};
      end else if (idx < 6'd52) begin
         r = 8'h61 + {2'b00, idx} - 8'd26;
      end else if (idx < 6'd62) begin
         r = 8'h30 + {2'b00, idx} - 8'd52;
      end else if (idx == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

endpackage

>>> sv/base64_stream_encoder_top.sv
// Base64 stream encoder: one byte in, up to six output characters out.
//
// Accepts raw bytes (req_) and emits Base64 ASCII characters (rsp_), one
// character per cycle while rsp_stall is low. A byte produces 1 to 6
// characters: one for a first or second byte of a group, two for a third
// (three if it ends a line), more on a last byte (pads, newlines). Each
// accepted byte's characters are computed combinationally into a six-entry
// character buffer, which drains through a single output register at one
// character per cycle unless rsp_stall holds it; the next byte is accepted
// in the cycle the buffer hands over its final character. Throughput is
// therefore set by the output register: mid-stream, a byte yields 4/3
// characters on average (2 for a third byte). line_feed_enable is written
// through csr_ (always ready) and adds a newline after every 76 characters
// plus a final newline; write it only while the encoder is idle.
`include "base64_stream_encoder_top_assert.svh"

module base64_stream_encoder_top (
   input  logic       clock,
   input  logic       reset,
   // byte input
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   // character output
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last,
   // configuration
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_line_feed_enable
);
   import b64e_pkg::*;

   logic            lfe_ff;
   phase_type       phase_ff, phase_in;
   logic [3:0]      left_ff, left_in;
   logic [4:0]      gil_ff, gil_in;
   logic [4:0]      gil_inc;
   logic [7:0]      buf_ff [MAX_CHARS];
   logic [7:0]      chars_in [MAX_CHARS];
   cnt_type         buf_cnt_ff, cnt_in;
   cnt_type         buf_idx_ff;
   logic            buf_last_ff;
   logic            buf_valid;
   logic            load;
   logic            final_char;
   logic            accept;
   logic            done;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_char_ff;
   logic            rsp_last_ff;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         lfe_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         lfe_ff <= csr_line_feed_enable;
      end
   end

   // buffer drain and input handshake
   assign buf_valid  = (buf_idx_ff < buf_cnt_ff);
   assign load       = buf_valid && (!rsp_valid_ff || !rsp_stall);
   assign final_char = (buf_idx_ff == buf_cnt_ff - cnt_type'(1));
   assign req_stall  = buf_valid && !(load && final_char);
   assign accept     = req_valid && !req_stall;

   // characters and next state for one byte
   always_comb begin
      for (int i = 0; i < MAX_CHARS; i++) begin
         chars_in[i] = PAD_CHAR;
      end
      cnt_in   = '0;
      done     = 1'b0;
      phase_in = phase_ff;
      left_in  = left_ff;
      gil_in   = gil_ff;
      gil_inc  = gil_ff + 5'd1;
      case (phase_ff)
         PH_SECOND: begin
            chars_in[0] = b64_char({left_ff[1:0], req_data_byte[7:4]});
            if (req_last_byte) begin
               chars_in[1] = b64_char({req_data_byte[3:0], 2'b00});
               chars_in[2] = PAD_CHAR;
               cnt_in      = cnt_type'(3);
               done        = 1'b1;
            end else begin
               cnt_in   = cnt_type'(1);
               left_in  = req_data_byte[3:0];
               phase_in = PH_THIRD;
            end
         end
         PH_THIRD: begin
            chars_in[0] = b64_char({left_ff, req_data_byte[7:6]});
            chars_in[1] = b64_char(req_data_byte[5:0]);
            cnt_in      = cnt_type'(2);
            done        = 1'b1;
         end
         default: begin
            chars_in[0] = b64_char(req_data_byte[7:2]);
            if (req_last_byte) begin
               chars_in[1] = b64_char({req_data_byte[1:0], 4'b0000});
               chars_in[2] = PAD_CHAR;
               chars_in[3] = PAD_CHAR;
               cnt_in      = cnt_type'(4);
               done        = 1'b1;
            end else begin
               cnt_in   = cnt_type'(1);
               left_in  = {2'b00, req_data_byte[1:0]};
               phase_in = PH_SECOND;
            end
         end
      endcase
      // group complete: count it, newline at the end of a line when line feeds are enabled
      if (done) begin
         if (gil_inc >= GROUPS_PER_LINE) begin
            gil_in = '0;
            if (lfe_ff) begin
               chars_in[cnt_in] = NEWLINE_CHAR;
               cnt_in           = cnt_in + cnt_type'(1);
            end
         end else begin
            gil_in = gil_inc;
         end
         phase_in = PH_FIRST;
         left_in  = '0;
      end
      // end of message: final newline when line feeds are enabled, back to start
      if (req_last_byte) begin
         if (lfe_ff) begin
            chars_in[cnt_in] = NEWLINE_CHAR;
            cnt_in           = cnt_in + cnt_type'(1);
         end
         phase_in = PH_FIRST;
         left_in  = '0;
         gil_in   = '0;
      end
   end

   // encoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         left_ff  <= '0;
         gil_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         gil_ff   <= gil_in;
      end
   end

   // character buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_cnt_ff <= '0;
         buf_idx_ff <= '0;
      end else if (accept) begin
         buf_cnt_ff <= cnt_in;
         buf_idx_ff <= '0;
      end else if (load) begin
         buf_idx_ff <= buf_idx_ff + cnt_type'(1);
      end
   end

   // character buffer payload
   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff      <= chars_in;
         buf_last_ff <= req_last_byte;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_char_ff <= buf_ff[buf_idx_ff];
         rsp_last_ff <= buf_last_ff && final_char;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_out_last = rsp_last_ff;

   // checks
   `B64E_ASSERT_NOW(a_idx_in_range, clock, reset, 1'b1, buf_idx_ff <= buf_cnt_ff)
   `B64E_ASSERT_NEXT(a_accept_fills, clock, reset, accept,
      buf_valid && (buf_idx_ff == '0))
   `B64E_ASSERT_NEXT(a_last_resets, clock, reset, accept && req_last_byte,
      (phase_ff == PH_FIRST) && (gil_ff == '0) && (left_ff == '0))

endmodule
